@@ design/mbfl_pkg.sv @@
// Package for the mailbox "From " line checker: request/response structs,
// status codes, prefix and name tables, and number range limits.
// No dependencies.
package mbfl_pkg;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] field_count;
      logic [2:0] number_index;
   } rsp_type;

   typedef logic [23:0] name_type;
   typedef logic [11:0] num_type;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NO_PREFIX = 3'd1;
   localparam logic [2:0] STATUS_FEW       = 3'd2;
   localparam logic [2:0] STATUS_BAD_DAY   = 3'd3;
   localparam logic [2:0] STATUS_BAD_MONTH = 3'd4;
   localparam logic [2:0] STATUS_NOT_DIGIT = 3'd5;
   localparam logic [2:0] STATUS_RANGE     = 3'd6;

   localparam logic [1:0] STRICT_LAX   = 2'd0;
   localparam logic [1:0] STRICT_COUNT = 2'd1;
   localparam logic [1:0] STRICT_RESET = 2'd2;

   localparam logic [2:0] PREFIX_LEN  = 3'd5;
   localparam logic [3:0] MAX_FIELDS  = 4'd10;
   localparam logic [3:0] MIN_FIELDS  = 4'd8;
   localparam int         NUM_SLOTS   = 7;
   localparam int         NUM_CHECKS  = 5;
   localparam num_type    NUM_SAT     = 12'd4095;

   localparam name_type DAY_NAMES [0:6] = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};
   localparam name_type MONTH_NAMES [0:11] = '{
      "Jan", "Feb", "Mar", "Apr", "May", "Jun",
      "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

   localparam num_type NUM_LOW  [0:4] = '{12'd1,  12'd0,  12'd0,  12'd0,  12'd1969};
   localparam num_type NUM_HIGH [0:4] = '{12'd31, 12'd23, 12'd59, 12'd60, 12'd2199};

   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0: c = "F";
         3'd1: c = "r";
         3'd2: c = "o";
         3'd3: c = "m";
         3'd4: c = " ";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

@@ design/mbox_from_line_checker.sv @@
// Mailbox "From " line checker, top level. Scans one byte per request and
// returns one status response per line. Depends on mbfl_pkg.
//
// One byte is taken every cycle while req_stall is low. The byte that
// carries last_byte clears the line state, and the state it yields goes into
// a line snapshot register, validated into the response register once that
// is free, while the next line streams in. Requests stall only while both
// the snapshot and the response register hold results and rsp_stall is
// high. Strictness (reset 2) is set through csr_wr_en / csr_wr_data; the
// user must write it only while the block is idle; this is not enforced.
module mbox_from_line_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mbfl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mbfl_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data
);

   logic [1:0] strict_ff;

   // line scan state
   logic [2:0] pfx_cnt_ff,  pfx_cnt_in;
   logic       pfx_fail_ff, pfx_fail_in;
   logic       line_end_ff, line_end_in;
   logic [3:0] fld_cnt_ff,  fld_cnt_in;
   logic       in_fld_ff,   in_fld_in;
   logic       stuck_ff,    stuck_in;
   logic       dig_run_ff,  dig_run_in;
   logic [1:0] day_cap_ff,  day_cap_in;
   logic [1:0] mon_cap_ff,  mon_cap_in;
   mbfl_pkg::name_type day_bytes_ff, day_bytes_in;
   mbfl_pkg::name_type mon_bytes_ff, mon_bytes_in;
   mbfl_pkg::num_type  num_val_ff [mbfl_pkg::NUM_SLOTS];
   mbfl_pkg::num_type  num_val_in [mbfl_pkg::NUM_SLOTS];
   logic [mbfl_pkg::NUM_SLOTS-1:0] num_dig_ff, num_dig_in;

   // line snapshot
   logic               snap_vld_ff;
   logic               snap_pfx_ok_ff;
   logic [3:0]         snap_fld_ff;
   logic               snap_day_full_ff;
   logic               snap_mon_full_ff;
   mbfl_pkg::name_type snap_day_ff;
   mbfl_pkg::name_type snap_mon_ff;
   mbfl_pkg::num_type  snap_val_ff [mbfl_pkg::NUM_SLOTS];
   logic [mbfl_pkg::NUM_SLOTS-1:0] snap_dig_ff;

   logic              rsp_vld_ff;
   mbfl_pkg::rsp_type rsp_data_ff;
   mbfl_pkg::rsp_type eval_rsp;

   logic       req_acc;
   logic       line_done;
   logic       snap_take;
   logic [7:0] b;
   logic       b_digit;
   logic       b_space;
   logic       b_colon;

   assign snap_take = !rsp_vld_ff || !rsp_stall;
   assign req_stall = snap_vld_ff && !snap_take;
   assign req_acc   = req_valid && !req_stall;
   assign line_done = req_acc && req_data.last_byte;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   assign b       = req_data.char_byte;
   assign b_digit = (b >= "0") && (b <= "9");
   assign b_space = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   assign b_colon = (b == ":");

   function automatic mbfl_pkg::num_type num_step(input mbfl_pkg::num_type v,
                                                  input logic [3:0] d);
      logic [15:0] s;
      s = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {12'd0, d};
      return (s > {4'd0, mbfl_pkg::NUM_SAT}) ? mbfl_pkg::NUM_SAT : s[11:0];
   endfunction

   // per-byte state update
   always_comb begin
      logic scan;
      logic [3:0] fld_next;
      scan         = 1'b0;
      fld_next     = fld_cnt_ff + 4'd1;
      pfx_cnt_in   = pfx_cnt_ff;
      pfx_fail_in  = pfx_fail_ff;
      line_end_in  = line_end_ff;
      fld_cnt_in   = fld_cnt_ff;
      in_fld_in    = in_fld_ff;
      stuck_in     = stuck_ff;
      dig_run_in   = dig_run_ff;
      day_cap_in   = day_cap_ff;
      mon_cap_in   = mon_cap_ff;
      day_bytes_in = day_bytes_ff;
      mon_bytes_in = mon_bytes_ff;
      num_val_in   = num_val_ff;
      num_dig_in   = num_dig_ff;

      if (!pfx_fail_ff) begin
         if (pfx_cnt_ff < mbfl_pkg::PREFIX_LEN) begin
            if (b == mbfl_pkg::prefix_char(pfx_cnt_ff)) begin
               pfx_cnt_in = pfx_cnt_ff + 3'd1;
            end else begin
               pfx_fail_in = 1'b1;
            end
         end else begin
            scan = 1'b1;
         end
      end

      if (scan) begin
         // pending name captures
         if (day_cap_ff == 2'd1) begin
            day_bytes_in[15:8] = b;
            day_cap_in = 2'd2;
         end else if (day_cap_ff == 2'd2) begin
            day_bytes_in[23:16] = b;
            day_cap_in = 2'd3;
         end
         if (mon_cap_ff == 2'd1) begin
            mon_bytes_in[15:8] = b;
            mon_cap_in = 2'd2;
         end else if (mon_cap_ff == 2'd2) begin
            mon_bytes_in[23:16] = b;
            mon_cap_in = 2'd3;
         end

         // leading-digit run of the current number field
         if (dig_run_ff) begin
            if (b_digit && (fld_cnt_ff >= 4'd4)) begin
               for (int k = 0; k < mbfl_pkg::NUM_SLOTS; k++) begin
                  if (fld_cnt_ff == 4'(k + 4)) begin
                     num_val_in[k] = num_step(num_val_ff[k], b[3:0]);
                  end
               end
            end else begin
               dig_run_in = 1'b0;
            end
         end

         if (!line_end_ff && !stuck_ff) begin
            priority if ((b == 8'h00) || (b == 8'h0A)) begin
               line_end_in = 1'b1;
               in_fld_in   = 1'b0;
            end else if (b[7]) begin
               // non-ASCII: all remaining fields start here
               stuck_in  = 1'b1;
               in_fld_in = 1'b0;
               if (fld_cnt_ff <= 4'd1) begin
                  day_bytes_in = {16'd0, b};
                  day_cap_in   = 2'd1;
               end
               if (fld_cnt_ff <= 4'd2) begin
                  mon_bytes_in = {16'd0, b};
                  mon_cap_in   = 2'd1;
               end
               for (int k = 0; k < mbfl_pkg::NUM_SLOTS; k++) begin
                  if (fld_cnt_ff <= 4'(k + 3)) begin
                     num_dig_in[k] = 1'b0;
                     num_val_in[k] = '0;
                  end
               end
               if (fld_cnt_ff < mbfl_pkg::MAX_FIELDS) begin
                  dig_run_in = 1'b0;
               end
               fld_cnt_in = mbfl_pkg::MAX_FIELDS;
            end else if (b_space) begin
               in_fld_in = 1'b0;
            end else if (in_fld_ff) begin
               if (b_colon && ((fld_cnt_ff == 4'd5) || (fld_cnt_ff == 4'd6))) begin
                  in_fld_in = 1'b0;
               end
            end else if (fld_cnt_ff < mbfl_pkg::MAX_FIELDS) begin
               if (fld_cnt_ff == 4'd1) begin
                  day_bytes_in = {16'd0, b};
                  day_cap_in   = 2'd1;
               end
               if (fld_cnt_ff == 4'd2) begin
                  mon_bytes_in = {16'd0, b};
                  mon_cap_in   = 2'd1;
               end
               for (int k = 0; k < mbfl_pkg::NUM_SLOTS; k++) begin
                  if (fld_cnt_ff == 4'(k + 3)) begin
                     num_dig_in[k] = b_digit;
                     num_val_in[k] = b_digit ? {8'd0, b[3:0]} : '0;
                  end
               end
               if (fld_cnt_ff >= 4'd3) begin
                  dig_run_in = b_digit;
               end
               fld_cnt_in = fld_next;
               in_fld_in  = !(b_colon && ((fld_next == 4'd5) || (fld_next == 4'd6)));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= mbfl_pkg::STRICT_RESET;
      end else if (csr_wr_en) begin
         strict_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || line_done) begin
         pfx_cnt_ff  <= '0;
         pfx_fail_ff <= 1'b0;
         line_end_ff <= 1'b0;
         fld_cnt_ff  <= '0;
         in_fld_ff   <= 1'b0;
         stuck_ff    <= 1'b0;
         dig_run_ff  <= 1'b0;
         day_cap_ff  <= '0;
         mon_cap_ff  <= '0;
      end else if (req_acc) begin
         pfx_cnt_ff  <= pfx_cnt_in;
         pfx_fail_ff <= pfx_fail_in;
         line_end_ff <= line_end_in;
         fld_cnt_ff  <= fld_cnt_in;
         in_fld_ff   <= in_fld_in;
         stuck_ff    <= stuck_in;
         dig_run_ff  <= dig_run_in;
         day_cap_ff  <= day_cap_in;
         mon_cap_ff  <= mon_cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         day_bytes_ff <= day_bytes_in;
         mon_bytes_ff <= mon_bytes_in;
         num_val_ff   <= num_val_in;
         num_dig_ff   <= num_dig_in;
      end
   end

   // snapshot of a finished line
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_vld_ff <= 1'b0;
      end else if (line_done) begin
         snap_vld_ff <= 1'b1;
      end else if (snap_take) begin
         snap_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (line_done) begin
         snap_pfx_ok_ff   <= !pfx_fail_in && (pfx_cnt_in == mbfl_pkg::PREFIX_LEN);
         snap_fld_ff      <= fld_cnt_in;
         snap_day_full_ff <= (day_cap_in == 2'd3);
         snap_mon_full_ff <= (mon_cap_in == 2'd3);
         snap_day_ff      <= day_bytes_in;
         snap_mon_ff      <= mon_bytes_in;
         snap_val_ff      <= num_val_in;
         snap_dig_ff      <= num_dig_in;
      end
   end

   // validation of the snapshot
   always_comb begin
      logic               day_hit;
      logic               mon_hit;
      logic               found;
      logic [2:0]         yr_slot;
      mbfl_pkg::name_type day_name;
      mbfl_pkg::name_type mon_name;
      mbfl_pkg::num_type  val;
      logic               dig;
      day_name = {snap_day_ff[7:0], snap_day_ff[15:8], snap_day_ff[23:16]};
      mon_name = {snap_mon_ff[7:0], snap_mon_ff[15:8], snap_mon_ff[23:16]};
      day_hit  = 1'b0;
      mon_hit  = 1'b0;
      for (int e = 0; e < 7; e++) begin
         if (day_name == mbfl_pkg::DAY_NAMES[e]) begin
            day_hit = 1'b1;
         end
      end
      for (int e = 0; e < 12; e++) begin
         if (mon_name == mbfl_pkg::MONTH_NAMES[e]) begin
            mon_hit = 1'b1;
         end
      end
      day_hit = day_hit && snap_day_full_ff;
      mon_hit = mon_hit && snap_mon_full_ff;

      yr_slot = 3'd4;
      if ((snap_fld_ff > 4'd8) && !snap_dig_ff[4]) begin
         yr_slot = 3'd5;
      end
      if ((snap_fld_ff > 4'd9) && !snap_dig_ff[yr_slot]) begin
         yr_slot = 3'd6;
      end

      eval_rsp.status       = mbfl_pkg::STATUS_OK;
      eval_rsp.field_count  = snap_fld_ff;
      eval_rsp.number_index = '0;
      found = 1'b0;
      val   = '0;
      dig   = 1'b0;

      priority if (!snap_pfx_ok_ff) begin
         eval_rsp.status      = mbfl_pkg::STATUS_NO_PREFIX;
         eval_rsp.field_count = '0;
      end else if (strict_ff == mbfl_pkg::STRICT_LAX) begin
         eval_rsp.status = mbfl_pkg::STATUS_OK;
      end else if (snap_fld_ff < mbfl_pkg::MIN_FIELDS) begin
         eval_rsp.status = mbfl_pkg::STATUS_FEW;
      end else if (strict_ff == mbfl_pkg::STRICT_COUNT) begin
         eval_rsp.status = mbfl_pkg::STATUS_OK;
      end else if (!day_hit) begin
         eval_rsp.status = mbfl_pkg::STATUS_BAD_DAY;
      end else if (!mon_hit) begin
         eval_rsp.status = mbfl_pkg::STATUS_BAD_MONTH;
      end else begin
         for (int i = 0; i < mbfl_pkg::NUM_CHECKS; i++) begin
            if (i < 4) begin
               val = snap_val_ff[i];
               dig = snap_dig_ff[i];
            end else begin
               val = snap_val_ff[yr_slot];
               dig = snap_dig_ff[yr_slot];
            end
            if (!found) begin
               if (!dig) begin
                  found = 1'b1;
                  eval_rsp.status       = mbfl_pkg::STATUS_NOT_DIGIT;
                  eval_rsp.number_index = 3'(i);
               end else if ((val < mbfl_pkg::NUM_LOW[i]) || (val > mbfl_pkg::NUM_HIGH[i])) begin
                  found = 1'b1;
                  eval_rsp.status       = mbfl_pkg::STATUS_RANGE;
                  eval_rsp.number_index = 3'(i);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (snap_take) begin
         rsp_vld_ff <= snap_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_take && snap_vld_ff) begin
         rsp_data_ff <= eval_rsp;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fld_cnt_ff <= mbfl_pkg::MAX_FIELDS)
      else $error("field count beyond ten");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == mbfl_pkg::STATUS_NO_PREFIX) |->
      rsp_data.field_count == 4'd0)
      else $error("prefix failure with nonzero field count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != mbfl_pkg::STATUS_NOT_DIGIT) &&
      (rsp_data.status != mbfl_pkg::STATUS_RANGE) |-> rsp_data.number_index == 3'd0)
      else $error("number index set without a number failure");

   assert property (@(posedge clock) disable iff (reset)
      snap_vld_ff && rsp_vld_ff && rsp_stall |-> req_stall)
      else $error("request taken while snapshot is blocked");

endmodule
